[hdl/framed_command_receiver_assert.svh]
// Assertion macros used by the receiver's executor module.
`ifndef FRAMED_COMMAND_RECEIVER_ASSERT_SVH
`define FRAMED_COMMAND_RECEIVER_ASSERT_SVH

// Implication checked on every clock, masked while in reset.
`define FCR_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while in reset.
`define FCR_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fcr_pkg.sv]
package fcr_pkg;
  localparam logic [7:0] SOF1 = 8'hAA;
  localparam logic [7:0] SOF2 = 8'h55;
  localparam logic [15:0] CCITT_GEN = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [7:0] OP_ARM = 8'h0A;
  localparam logic [7:0] OP_DISARM = 8'h0B;
  localparam logic [7:0] OP_RAWMODE = 8'h20;
  localparam logic [7:0] OP_GOAL = 8'h21;
  localparam logic [7:0] OP_SETMODE = 8'h22;
  localparam logic [7:0] OP_WAYPT = 8'h23;
  localparam logic [7:0] OP_BASE = 8'h24;
  localparam logic [7:0] OP_RAWWP = 8'h25;
  localparam logic [7:0] OP_RAWBASE = 8'h26;
  localparam logic [7:0] OP_MODE0 = 8'h30;
  localparam logic [7:0] OP_MODE3 = 8'h33;
  localparam logic [7:0] OP_FLUSH = 8'h69;

  localparam logic [3:0] EV_ARM = 4'd0;
  localparam logic [3:0] EV_DISARM = 4'd1;
  localparam logic [3:0] EV_MODE = 4'd2;
  localparam logic [3:0] EV_WAYPT = 4'd3;
  localparam logic [3:0] EV_BASE = 4'd4;
  localparam logic [3:0] EV_GOAL = 4'd5;
  localparam logic [3:0] EV_FLUSH = 4'd6;
  localparam logic [3:0] EV_UNKNOWN = 4'd7;
  localparam logic [3:0] EV_CRC = 4'd8;
  localparam logic [3:0] EV_VER = 4'd9;

  localparam logic [3:0] CMD_NONE = 4'd0;
  localparam logic [3:0] CMD_ARM = 4'd1;
  localparam logic [3:0] CMD_DISARM = 4'd2;
  localparam logic [3:0] CMD_MODE = 4'd3;
  localparam logic [3:0] CMD_WAYPT = 4'd4;
  localparam logic [3:0] CMD_BASE = 4'd5;

  localparam logic [0:0] REG_RAW_EN = 1'd0;
  localparam logic [0:0] REG_VERSION = 1'd1;

  // Classified command handed from the parser to the executor.
  typedef struct packed {
    logic [3:0]  event_code;
    logic        from_frame;
    logic [7:0]  message_type;
    logic [3:0]  cmd;
    logic [7:0]  mode_arg;
    logic [31:0] lat;
    logic [31:0] lon;
  } fcr_cmd_t;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CCITT_GEN) : {r[14:0], 1'b0};
    end
    return r;
  endfunction
endpackage

[hdl/framed_command_receiver.sv]
// A completed command is queued, then registered into the executor outputs.
// Throughput: one byte per cycle unless the queue is full; the byte-wide CRC update
// and parse step are combinational; a two-entry command queue decouples parser and executor.
// Reset (synchronous, rst_n low): parser hunts, state flags and mode clear,
// raw_commands_enable = 1, expected_version = 1.
module framed_command_receiver import fcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_event_code,
  output logic        out_from_frame,
  output logic [7:0]  out_message_type,
  output logic [7:0]  out_mode_now,
  output logic        out_armed_now,
  output logic        out_waypoint_valid,
  output logic        out_base_requested,
  output logic signed [31:0] out_coord_lat,
  output logic signed [31:0] out_coord_lon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic       raw_en_r;
  logic [7:0] ver_r;
  logic       cmd_valid, q_full, q_empty, q_rd, in_acc;
  fcr_cmd_t   cmd, q_data;

  // Stall only when the queue is full; otherwise a free slot absorbs a new transaction.
  assign in_stall = q_full;
  assign in_acc = in_valid && !q_full;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_en_r <= 1'b1;
      ver_r <= 8'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_RAW_EN: raw_en_r <= pwdata[0];
        REG_VERSION: ver_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RAW_EN: prdata = {31'd0, raw_en_r};
      REG_VERSION: prdata = {24'd0, ver_r};
      default: prdata = '0;
    endcase
  end

  fcr_parser u_parser (
    .clk, .rst_n, .raw_en(raw_en_r), .exp_ver(ver_r),
    .byte_valid(in_acc), .byte_data(in_rx_byte), .cmd_valid, .cmd
  );

  fcr_cmd_fifo u_fifo (
    .clk, .rst_n, .wr_en(cmd_valid), .wr_data(cmd), .full(q_full),
    .rd_en(q_rd), .empty(q_empty), .rd_data(q_data)
  );

  fcr_executor u_exec (
    .clk, .rst_n, .q_empty, .q_data, .q_rd, .out_valid, .out_stall,
    .out_event_code, .out_from_frame, .out_message_type, .out_mode_now,
    .out_armed_now, .out_waypoint_valid, .out_base_requested,
    .out_coord_lat, .out_coord_lon
  );
endmodule

[hdl/fcr_parser.sv]
module fcr_parser import fcr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       raw_en,
  input  logic [7:0] exp_ver,
  input  logic       byte_valid,
  input  logic [7:0] byte_data,
  output logic       cmd_valid,
  output fcr_cmd_t   cmd
);
  localparam logic [3:0] PH_HUNT = 4'd0, PH_SOF2 = 4'd1, PH_VER = 4'd2, PH_TYPE = 4'd3,
    PH_SEQ = 4'd4, PH_LEN = 4'd5, PH_PAY = 4'd6, PH_CRCLO = 4'd7, PH_CRCHI = 4'd8,
    PH_RAWMODE = 4'd9, PH_RAWWP = 4'd10;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  ver_r, type_r, len_r, cnt_r, crclo_r, rawop_r;
  logic [15:0] crc_r;
  logic [7:0]  pay_r [8];
  logic [7:0]  pay_now [8];
  logic [15:0] crc_upd;
  logic [7:0]  cnt_inc;
  logic [31:0] lat_w, lon_w;

  assign crc_upd = crc_byte(crc_r, byte_data);
  assign cnt_inc = cnt_r + 8'd1;

  // Payload view; in raw waypoint mode it includes the byte arriving now.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pay_now[i] = pay_r[i];
    end
    if (phase_r == PH_RAWWP) pay_now[cnt_r[2:0]] = byte_data;
    lat_w = {pay_now[3], pay_now[2], pay_now[1], pay_now[0]};
    lon_w = {pay_now[7], pay_now[6], pay_now[5], pay_now[4]};
  end

  always_comb begin
    phase_nxt = phase_r;
    cmd_valid = 1'b0;
    cmd = '{event_code: EV_UNKNOWN, from_frame: 1'b1, message_type: type_r, cmd: CMD_NONE,
            mode_arg: pay_now[0], lat: lat_w, lon: lon_w};
    case (phase_r)
      PH_HUNT: begin
        cmd.from_frame = 1'b0;
        cmd.message_type = byte_data;
        if (byte_data == SOF1) phase_nxt = PH_SOF2;
        else if (raw_en) begin
          case (byte_data)
            OP_ARM: begin
              cmd_valid = 1'b1; cmd.event_code = EV_ARM; cmd.cmd = CMD_ARM;
            end
            OP_DISARM: begin
              cmd_valid = 1'b1; cmd.event_code = EV_DISARM; cmd.cmd = CMD_DISARM;
            end
            OP_RAWBASE: begin
              cmd_valid = 1'b1; cmd.event_code = EV_BASE; cmd.cmd = CMD_BASE;
            end
            OP_RAWMODE: phase_nxt = PH_RAWMODE;
            OP_RAWWP: phase_nxt = PH_RAWWP;
            default: ;
          endcase
        end
      end
      PH_SOF2: begin
        if (byte_data == SOF2) phase_nxt = PH_VER;
        else if (byte_data != SOF1) phase_nxt = PH_HUNT;
      end
      PH_VER: phase_nxt = PH_TYPE;
      PH_TYPE: phase_nxt = PH_SEQ;
      PH_SEQ: phase_nxt = PH_LEN;
      PH_LEN: phase_nxt = (byte_data == 8'd0) ? PH_CRCLO : PH_PAY;
      PH_PAY: if (cnt_inc == len_r) phase_nxt = PH_CRCLO;
      PH_CRCLO: phase_nxt = PH_CRCHI;
      PH_CRCHI: begin
        phase_nxt = PH_HUNT;
        cmd_valid = 1'b1;
        if (ver_r != exp_ver) cmd.event_code = EV_VER;
        else if ({byte_data, crclo_r} != crc_r) cmd.event_code = EV_CRC;
        else if (type_r == OP_ARM && len_r == 8'd0) begin
          cmd.event_code = EV_ARM; cmd.cmd = CMD_ARM;
        end else if (type_r == OP_DISARM && len_r == 8'd0) begin
          cmd.event_code = EV_DISARM; cmd.cmd = CMD_DISARM;
        end else if (type_r >= OP_MODE0 && type_r <= OP_MODE3 && len_r == 8'd0) begin
          cmd.event_code = EV_MODE; cmd.cmd = CMD_MODE; cmd.mode_arg = type_r - OP_MODE0;
        end else if (type_r == OP_SETMODE && len_r == 8'd1) begin
          cmd.event_code = EV_MODE; cmd.cmd = CMD_MODE;
        end else if (type_r == OP_WAYPT && len_r == 8'd8) begin
          cmd.event_code = EV_WAYPT; cmd.cmd = CMD_WAYPT;
        end else if (type_r == OP_BASE && len_r == 8'd0) begin
          cmd.event_code = EV_BASE; cmd.cmd = CMD_BASE;
        end else if (type_r == OP_GOAL && len_r == 8'd8) begin
          cmd.event_code = EV_GOAL;
        end else if (type_r == OP_FLUSH && len_r == 8'd0) begin
          cmd.event_code = EV_FLUSH;
        end
      end
      PH_RAWMODE: begin
        phase_nxt = PH_HUNT;
        cmd_valid = 1'b1;
        cmd.from_frame = 1'b0; cmd.message_type = rawop_r;
        cmd.event_code = EV_MODE; cmd.cmd = CMD_MODE; cmd.mode_arg = byte_data;
      end
      PH_RAWWP: begin
        if (cnt_inc >= 8'd8) begin
          phase_nxt = PH_HUNT;
          cmd_valid = 1'b1;
          cmd.from_frame = 1'b0; cmd.message_type = rawop_r;
          cmd.event_code = EV_WAYPT; cmd.cmd = CMD_WAYPT;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
    if (!byte_valid) begin
      phase_nxt = phase_r;
      cmd_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      ver_r <= '0; type_r <= '0; len_r <= '0; cnt_r <= '0;
      crclo_r <= '0; rawop_r <= '0; crc_r <= CRC_INIT;
    end else if (byte_valid) begin
      phase_r <= phase_nxt;
      case (phase_r)
        PH_HUNT: begin
          if (byte_data == OP_RAWMODE || byte_data == OP_RAWWP) rawop_r <= byte_data;
          if (byte_data == OP_RAWWP) cnt_r <= '0;
        end
        PH_SOF2: if (byte_data == SOF2) crc_r <= CRC_INIT;
        PH_VER: begin ver_r <= byte_data; crc_r <= crc_upd; end
        PH_TYPE: begin type_r <= byte_data; crc_r <= crc_upd; end
        PH_SEQ: crc_r <= crc_upd;
        PH_LEN: begin len_r <= byte_data; crc_r <= crc_upd; cnt_r <= '0; end
        PH_PAY: begin crc_r <= crc_upd; cnt_r <= cnt_inc; end
        PH_CRCLO: crclo_r <= byte_data;
        PH_RAWWP: cnt_r <= (cnt_inc >= 8'd8) ? 8'd0 : cnt_inc;
        default: ;
      endcase
    end
  end

  // Payload store: written only inside a frame or raw waypoint.
  always_ff @(posedge clk) begin
    if (byte_valid) begin
      if ((phase_r == PH_PAY && cnt_r < 8'd8) || phase_r == PH_RAWWP)
        pay_r[cnt_r[2:0]] <= byte_data;
    end
  end
endmodule

[hdl/fcr_cmd_fifo.sv]
module fcr_cmd_fifo import fcr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  fcr_cmd_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output logic     empty,
  output fcr_cmd_t rd_data
);
  fcr_cmd_t    mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

[hdl/fcr_executor.sv]
module fcr_executor import fcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  fcr_cmd_t    q_data,
  output logic        q_rd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_event_code,
  output logic        out_from_frame,
  output logic [7:0]  out_message_type,
  output logic [7:0]  out_mode_now,
  output logic        out_armed_now,
  output logic        out_waypoint_valid,
  output logic        out_base_requested,
  output logic signed [31:0] out_coord_lat,
  output logic signed [31:0] out_coord_lon
);
  `include "framed_command_receiver_assert.svh"

  logic [7:0]  mode_r, mode_nxt;
  logic        armed_r, armed_nxt, wp_r, wp_nxt, base_r, base_nxt;
  logic [31:0] lat_r, lat_nxt, lon_r, lon_nxt;
  logic        ov_r;

  assign q_rd = !q_empty && (!ov_r || !out_stall);
  assign out_valid = ov_r;

  always_comb begin
    mode_nxt = mode_r; armed_nxt = armed_r; wp_nxt = wp_r; base_nxt = base_r;
    lat_nxt = lat_r; lon_nxt = lon_r;
    case (q_data.cmd)
      CMD_ARM: armed_nxt = 1'b1;
      CMD_DISARM: armed_nxt = 1'b0;
      CMD_MODE: mode_nxt = q_data.mode_arg;
      CMD_WAYPT: begin wp_nxt = 1'b1; lat_nxt = q_data.lat; lon_nxt = q_data.lon; end
      CMD_BASE: base_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; mode_r <= '0; armed_r <= 1'b0; wp_r <= 1'b0; base_r <= 1'b0;
      lat_r <= '0; lon_r <= '0;
    end else begin
      if (q_rd) begin
        ov_r <= 1'b1;
        mode_r <= mode_nxt; armed_r <= armed_nxt; wp_r <= wp_nxt; base_r <= base_nxt;
        lat_r <= lat_nxt; lon_r <= lon_nxt;
      end else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      out_event_code <= q_data.event_code;
      out_from_frame <= q_data.from_frame;
      out_message_type <= q_data.message_type;
      out_coord_lat <= (q_data.event_code == EV_GOAL) ? q_data.lat : lat_nxt;
      out_coord_lon <= (q_data.event_code == EV_GOAL) ? q_data.lon : lon_nxt;
    end
  end

  assign out_mode_now = mode_r;
  assign out_armed_now = armed_r;
  assign out_waypoint_valid = wp_r;
  assign out_base_requested = base_r;

  `FCR_ASSERT_NXT(a_wp_sticky, clk, rst_n, wp_r, wp_r, "waypoint flag cleared")
  `FCR_ASSERT_NXT(a_base_sticky, clk, rst_n, base_r, base_r, "base flag cleared")
  `FCR_ASSERT_NXT(a_hold, clk, rst_n, ov_r && out_stall, ov_r && $stable(out_event_code),
                  "stalled result changed")
endmodule
